// ===== rtl/tjme_pkg.sv =====
`default_nettype none

package tjme_pkg;

  localparam int unsigned ModeW     = 2;
  localparam int unsigned KeyW      = 32;
  localparam int unsigned TagFieldW = 16;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned OpW       = 3;

  localparam logic [ModeW-1:0] ModeLoad  = 2'd0;
  localparam logic [ModeW-1:0] ModeProbe = 2'd1;
  localparam logic [ModeW-1:0] ModeClear = 2'd2;

  localparam logic [StatusW-1:0] StatusMatch   = 2'd0;
  localparam logic [StatusW-1:0] StatusNoMatch = 2'd1;
  localparam logic [StatusW-1:0] StatusDropped = 2'd2;

  localparam logic [OpW-1:0] OpLt = 3'd0;
  localparam logic [OpW-1:0] OpGt = 3'd1;
  localparam logic [OpW-1:0] OpGe = 3'd2;
  localparam logic [OpW-1:0] OpLe = 3'd3;
  localparam logic [OpW-1:0] OpEq = 3'd4;
  localparam logic [OpW-1:0] OpNe = 3'd5;

  localparam logic [OpW-1:0] CompareOpReset     = OpEq;
  localparam logic           StoredIsFirstReset = 1'b0;

  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = OpW;
  localparam logic [CfgAddrW-1:0] CfgCompareOp    = 1'd0;
  localparam logic [CfgAddrW-1:0] CfgStoredIsFirst = 1'd1;

  typedef struct packed {
    logic load_wr;
    logic clear;
    logic probe_start;
    logic scan_en;
    logic emit_final;
    logic emit_drop;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
    logic store_full;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/tjme_ram.sv =====
`default_nettype none

module tjme_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tjme_ctrl.sv =====
`default_nettype none

module tjme_ctrl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic [tjme_pkg::ModeW-1:0] mode_i,
  output logic                          in_ready_o,
  input  wire tjme_pkg::dp_sts_t        sts_i,
  output tjme_pkg::dp_cmd_t             cmd_o
);

  import tjme_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StFinal = 2'd2;
  localparam logic [1:0] StDrop  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       in_fire;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          unique case (mode_i)
            ModeLoad: begin
              if (sts_i.store_full) begin
                state_d = StDrop;
              end else begin
                cmd_o.load_wr = 1'b1;
              end
            end
            ModeProbe: begin
              cmd_o.probe_start = 1'b1;
              state_d           = StScan;
            end
            ModeClear: begin
              cmd_o.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      StScan: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_done) begin
          state_d = StFinal;
        end
      end
      StFinal: begin
        if (sts_i.out_free) begin
          cmd_o.emit_final = 1'b1;
          state_d          = StIdle;
        end
      end
      StDrop: begin
        if (sts_i.out_free) begin
          cmd_o.emit_drop = 1'b1;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tjme_dp.sv =====
`default_nettype none

module tjme_dp #(
  parameter int unsigned STORE_DEPTH = 64,
  parameter int unsigned TAG_BITS    = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tjme_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [tjme_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic [tjme_pkg::KeyW-1:0]      key_i,
  input  wire logic [tjme_pkg::TagFieldW-1:0] tag_i,
  input  wire tjme_pkg::dp_cmd_t             cmd_i,
  output tjme_pkg::dp_sts_t                  sts_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [tjme_pkg::TagFieldW-1:0]     first_tag_o,
  output logic [tjme_pkg::TagFieldW-1:0]     second_tag_o,
  output logic [tjme_pkg::StatusW-1:0]       status_o,
  output logic                               last_o
);

  import tjme_pkg::*;

  localparam int unsigned TagW  = (TAG_BITS < TagFieldW) ? TAG_BITS : TagFieldW;
  localparam int unsigned AddrW = $clog2(STORE_DEPTH);
  localparam int unsigned CntW  = $clog2(STORE_DEPTH + 1);
  localparam int unsigned RamW  = KeyW + TagW;

  logic [OpW-1:0]  op_q;
  logic            sif_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] addr_q, addr_d;
  logic            rvalid_q, rvalid_d;
  logic            pend_q, pend_d;
  logic [TagW-1:0] pend_tag_q;
  logic signed [KeyW-1:0] key_q;
  logic [TagW-1:0] ptag_q;

  logic            ov_q, ov_d;
  logic [TagFieldW-1:0] first_q, second_q;
  logic [StatusW-1:0]   status_q;
  logic            last_q;

  logic [RamW-1:0] rdata;
  logic signed [KeyW-1:0] skey;
  logic [TagW-1:0] stag;
  logic signed [KeyW-1:0] lhs, rhs;
  logic            lt, eq, hit;
  logic            out_free, advance, issue, consume, emit_scan, emit;

  tjme_ram #(
    .WIDTH(RamW),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load_wr),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i({tag_i[TagW-1:0], key_i}),
    .re_i   (issue),
    .raddr_i(addr_q[AddrW-1:0]),
    .rdata_o(rdata)
  );

  assign skey = rdata[KeyW-1:0];
  assign stag = rdata[RamW-1:KeyW];

  // The comparison is always first-relation key against second-relation key.
  assign lhs = sif_q ? skey : key_q;
  assign rhs = sif_q ? key_q : skey;
  assign lt  = lhs < rhs;
  assign eq  = lhs == rhs;

  always_comb begin
    unique case (op_q)
      OpLt:    hit = lt;
      OpGt:    hit = !lt && !eq;
      OpGe:    hit = !lt;
      OpLe:    hit = lt || eq;
      OpEq:    hit = eq;
      OpNe:    hit = !eq;
      default: hit = 1'b0;
    endcase
  end

  assign out_free  = !ov_q || out_ready_i;
  assign advance   = !rvalid_q || !hit || !pend_q || out_free;
  assign issue     = cmd_i.scan_en && advance && (addr_q < count_q);
  assign consume   = cmd_i.scan_en && rvalid_q && advance;
  assign emit_scan = consume && hit && pend_q;
  assign emit      = emit_scan || cmd_i.emit_final || cmd_i.emit_drop;

  assign sts_o.scan_done  = (addr_q == count_q) && !rvalid_q;
  assign sts_o.out_free   = out_free;
  assign sts_o.store_full = (count_q == CntW'(STORE_DEPTH));

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.load_wr) begin
      count_d = count_q + 1'b1;
    end
    addr_d   = addr_q;
    rvalid_d = rvalid_q;
    pend_d   = pend_q;
    if (cmd_i.probe_start) begin
      addr_d   = '0;
      rvalid_d = 1'b0;
      pend_d   = 1'b0;
    end else begin
      if (issue) begin
        addr_d = addr_q + 1'b1;
      end
      if (cmd_i.scan_en && advance) begin
        rvalid_d = issue;
      end
      if (consume && hit) begin
        pend_d = 1'b1;
      end
    end
    ov_d = ov_q;
    if (emit) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= CompareOpReset;
      sif_q    <= StoredIsFirstReset;
      count_q  <= '0;
      addr_q   <= '0;
      rvalid_q <= 1'b0;
      pend_q   <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CfgCompareOp:     op_q  <= cfg_data_i;
          CfgStoredIsFirst: sif_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      count_q  <= count_d;
      addr_q   <= addr_d;
      rvalid_q <= rvalid_d;
      pend_q   <= pend_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_start) begin
      key_q  <= key_i;
      ptag_q <= tag_i[TagW-1:0];
    end
    if (consume && hit) begin
      pend_tag_q <= stag;
    end
    if (cmd_i.emit_drop) begin
      first_q  <= '0;
      second_q <= '0;
      status_q <= StatusDropped;
      last_q   <= 1'b1;
    end else if (cmd_i.emit_final && !pend_q) begin
      first_q  <= sif_q ? '0 : TagFieldW'(ptag_q);
      second_q <= sif_q ? TagFieldW'(ptag_q) : '0;
      status_q <= StatusNoMatch;
      last_q   <= 1'b1;
    end else if (emit) begin
      first_q  <= sif_q ? TagFieldW'(pend_tag_q) : TagFieldW'(ptag_q);
      second_q <= sif_q ? TagFieldW'(ptag_q) : TagFieldW'(pend_tag_q);
      status_q <= StatusMatch;
      last_q   <= cmd_i.emit_final;
    end
  end

  assign out_valid_o  = ov_q;
  assign first_tag_o  = first_q;
  assign second_tag_o = second_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

// ===== rtl/theta_join_match_engine_top.sv =====
// Theta-join match engine. Input items arrive on the s_axis channel with the
// mode in tuser: a load writes the row into the next free store entry, a
// clear empties the store, and a probe compares its key with every stored
// row in entry order. Results leave on the m_axis channel, one pair of tags
// per match, with the status in tuser and tlast on the final result of the
// item. A probe with no match gives one no-match result, and a load into a
// full store gives one dropped result.
// Loads, clears and unused modes give no result; a dropped load holds
// s_axis_tready low until the output register is free for its result.
// A probe reads one store entry per cycle unless the output stalls, and keeps
// one match back so that the final result can carry tlast. It holds
// s_axis_tready low until its final result enters the output register.
// When the receiver stalls, the scan halts at the next match that needs the
// output register and resumes once it drains. Reset empties the store and
// sets the operator to equality with the probe rows as the first relation.
// The user must write configuration through cfg_we_i only while the block is idle; the block does not enforce it.
`default_nettype none

module theta_join_match_engine_top #(
  parameter int unsigned STORE_DEPTH = 64,
  parameter int unsigned TAG_BITS    = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tjme_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [tjme_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // Fields from bit 0: key, row_tag.
  input  wire logic [47:0]                    s_axis_tdata_i,
  // Fields from bit 0: mode.
  input  wire logic [tjme_pkg::ModeW-1:0]     s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // Fields from bit 0: first_tag, second_tag.
  output logic [31:0]                         m_axis_tdata_o,
  // Fields from bit 0: status.
  output logic [tjme_pkg::StatusW-1:0]        m_axis_tuser_o,
  output logic                                m_axis_tlast_o
);

  import tjme_pkg::*;

  dp_cmd_t              cmd;
  dp_sts_t              sts;
  logic [TagFieldW-1:0] first_tag, second_tag;

  tjme_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .mode_i    (s_axis_tuser_i),
    .in_ready_o(s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tjme_dp #(
    .STORE_DEPTH(STORE_DEPTH),
    .TAG_BITS   (TAG_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .key_i       (s_axis_tdata_i[KeyW-1:0]),
    .tag_i       (s_axis_tdata_i[KeyW+TagFieldW-1:KeyW]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .first_tag_o (first_tag),
    .second_tag_o(second_tag),
    .status_o    (m_axis_tuser_o),
    .last_o      (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {second_tag, first_tag};

endmodule

`default_nettype wire
